>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the voice allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pva_pkg.sv
// Package with the types and constants of the voice allocator.
`timescale 1ns / 1ps

package pva_pkg;

  localparam int VOICES_DEF = 8;
  localparam int VIDX_W     = 6;
  localparam int MAX_RES    = 8;
  localparam int CNT_W      = 4;

  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_STATUS   = 2'd2;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [2:0]  voice_sel;
    logic        voice_active;
    logic [15:0] voice_energy;
  } item_t;

  typedef struct packed {
    logic [2:0] voice;
    logic       action;
    logic [6:0] note_out;
    logic [6:0] velocity_out;
    logic       last;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [6:0]        note;
    logic [6:0]        velocity;
    logic              found_match;
    logic [VIDX_W-1:0] match_idx;
    logic              found_free;
    logic [VIDX_W-1:0] free_idx;
    logic [VIDX_W-1:0] min_idx;
    logic [15:0]       min_level;
    logic              pend_valid;
    logic [VIDX_W-1:0] pend_idx;
    logic [CNT_W-1:0]  count;
  } probe_t;

  typedef struct packed {
    logic              valid;
    logic              status;
    logic [VIDX_W-1:0] idx;
    logic              on;
    logic [6:0]        note;
    logic [15:0]       level;
  } vwrite_t;

endpackage

>>> rtl/poly_voice_allocator.sv
// Top level of the voice allocator: entry register, chain of voice cells, result register.
//
//   Channel  Direction  Handshake                 Payload
//   item     in         item_valid / item_stall   pva_pkg::item_t
//   result   out        result_valid / result_stall  pva_pkg::result_t
//
// A note event enters a register and then walks the chain of VOICES cells, one cell
// per cycle while the result side does not stall.
// A status report is written straight to the addressed voice; it and an unused op code do not enter the chain.
// Only one note event is in the chain at a time; item_stall is high while it is there.
// Reset clears all voice state at once; no clearing pass is needed.
// A stalled result register freezes the whole chain until the transfer completes.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module poly_voice_allocator #(
  parameter int VOICES = pva_pkg::VOICES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  pva_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output pva_pkg::result_t result
);
  import pva_pkg::*;

  wire probe_t link [VOICES+1];

  probe_t            entry;
  probe_t            entry_next;
  probe_t            fin;
  vwrite_t           wr;
  logic              adv;
  logic              take;
  logic              is_on;
  logic              is_rel;
  logic              is_stat;
  logic [VOICES:0]   live;
  logic [VOICES-1:0] emit;
  result_t           emit_res [VOICES];
  logic              emit_any;
  result_t           res_mux;
  logic [VIDX_W-1:0] pick;

  assign link[0] = entry;
  assign fin = link[VOICES];

  for (genvar k = 0; k < VOICES; k++) begin : g_cell
    pva_cell #(.IDX(k)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .adv         (adv),
      .probe_in    (link[k]),
      .wr          (wr),
      .probe_out   (link[k+1]),
      .emit        (emit[k]),
      .emit_result (emit_res[k])
    );
  end

  always_comb begin
    for (int k = 0; k <= VOICES; k++) begin
      live[k] = link[k].valid;
    end
  end

  assign adv = !result_valid || !result_stall;
  assign item_stall = |live;
  assign take = item_valid && !item_stall;

  always_comb begin
    is_on = 1'b0;
    is_rel = 1'b0;
    is_stat = 1'b0;
    unique case (item.op)
      OP_NOTE_ON: begin
        is_on = (item.velocity != '0);
        is_rel = (item.velocity == '0);
      end
      OP_NOTE_OFF: is_rel = 1'b1;
      OP_STATUS:   is_stat = 1'b1;
      default:     is_stat = 1'b0;
    endcase
  end

  always_comb begin
    entry_next = '0;
    entry_next.valid = is_on || is_rel;
    entry_next.kind = is_on ? ACT_START : ACT_RELEASE;
    entry_next.note = item.note;
    entry_next.velocity = item.velocity;
    entry_next.min_level = '1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (take) begin
      entry <= entry_next;
    end else if (adv) begin
      entry.valid <= 1'b0;
    end
  end

  always_comb begin
    if (fin.found_match) begin
      pick = fin.match_idx;
    end else if (fin.found_free) begin
      pick = fin.free_idx;
    end else begin
      pick = fin.min_idx;
    end
  end

  always_comb begin
    wr = '0;
    if (take && is_stat) begin
      wr.valid = 1'b1;
      wr.status = 1'b1;
      wr.idx = VIDX_W'(item.voice_sel);
      wr.on = item.voice_active;
      wr.level = item.voice_energy;
    end else if (adv && fin.valid && (fin.kind == ACT_START)) begin
      wr.valid = 1'b1;
      wr.idx = pick;
      wr.on = 1'b1;
      wr.note = fin.note;
    end
  end

  always_comb begin
    emit_any = 1'b0;
    res_mux = '0;
    for (int k = 0; k < VOICES; k++) begin
      if (emit[k]) begin
        emit_any = 1'b1;
        res_mux = emit_res[k];
      end
    end
    if (fin.valid && (fin.kind == ACT_START)) begin
      emit_any = 1'b1;
      res_mux.voice = pick[2:0];
      res_mux.action = ACT_START;
      res_mux.note_out = fin.note;
      res_mux.velocity_out = fin.velocity;
      res_mux.last = 1'b1;
    end else if (fin.valid && fin.pend_valid) begin
      emit_any = 1'b1;
      res_mux.voice = fin.pend_idx[2:0];
      res_mux.action = ACT_RELEASE;
      res_mux.note_out = fin.note;
      res_mux.velocity_out = '0;
      res_mux.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= emit_any;
      if (emit_any) begin
        result <= res_mux;
      end
    end
  end

  `ASSERT_IMPLIES(a_one_probe, clk, rst, 1'b1, $onehot0(live), "More than one probe in the chain.")
  `ASSERT_IMPLIES(a_start_last, clk, rst, result_valid && (result.action == ACT_START), result.last, "A start transfer is not marked last.")
  `ASSERT_IMPLIES(a_release_vel, clk, rst, result_valid && (result.action == ACT_RELEASE), result.velocity_out == 7'd0, "A release transfer carries a velocity.")
  `ASSERT_NEXT(a_take_busy, clk, rst, take && (is_on || is_rel), item_stall, "A note event did not enter the chain.")

endmodule

>>> rtl/pva_cell.sv
// One voice cell: holds the voice state and updates the probe passing through it.
`timescale 1ns / 1ps

module pva_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  pva_pkg::probe_t  probe_in,
  input  pva_pkg::vwrite_t wr,
  output pva_pkg::probe_t  probe_out,
  output logic             emit,
  output pva_pkg::result_t emit_result
);
  import pva_pkg::*;

  localparam logic [VIDX_W-1:0] MY_IDX = VIDX_W'(IDX);

  logic [6:0]  voice_note;
  logic        voice_on;
  logic [15:0] voice_level;
  logic        hit;
  probe_t      probe_next;

  always_comb begin
    hit = voice_on && (voice_note == probe_in.note);
    probe_next = probe_in;
    emit = 1'b0;
    emit_result.voice = probe_in.pend_idx[2:0];
    emit_result.action = ACT_RELEASE;
    emit_result.note_out = probe_in.note;
    emit_result.velocity_out = '0;
    emit_result.last = 1'b0;
    if (probe_in.valid) begin
      if (probe_in.kind == ACT_START) begin
        if (hit && !probe_in.found_match) begin
          probe_next.found_match = 1'b1;
          probe_next.match_idx = MY_IDX;
        end
        if (!voice_on && !probe_in.found_free) begin
          probe_next.found_free = 1'b1;
          probe_next.free_idx = MY_IDX;
        end
        if ((IDX == 0) || (voice_level < probe_in.min_level)) begin
          probe_next.min_level = voice_level;
          probe_next.min_idx = MY_IDX;
        end
      end else if (hit && (probe_in.count < CNT_W'(MAX_RES))) begin
        emit = probe_in.pend_valid;
        probe_next.pend_valid = 1'b1;
        probe_next.pend_idx = MY_IDX;
        probe_next.count = probe_in.count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_note <= '0;
      voice_on <= 1'b0;
      voice_level <= '0;
    end else if (wr.valid && (wr.idx == MY_IDX)) begin
      voice_on <= wr.on;
      if (wr.status) begin
        voice_level <= wr.level;
      end else begin
        voice_note <= wr.note;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else if (adv) begin
      probe_out <= probe_next;
    end
  end

endmodule
